// File: rtl/lar_pkg.sv
// Shared types for the look-at rotation basis pipeline.
// Holds the request and result words and the axis and wide vector types.
// Depends on nothing.
package lar_pkg;

	localparam int AXIS_W = 32;
	localparam int WIDE_W = 64;

	typedef logic signed [AXIS_W-1:0] axis_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	typedef struct packed {
		logic signed [31:0] eye_x;
		logic signed [31:0] eye_y;
		logic signed [31:0] eye_z;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
		logic signed [31:0] up_x;
		logic signed [31:0] up_y;
		logic signed [31:0] up_z;
	} req_t;

	typedef struct packed {
		logic signed [31:0] right_x;
		logic signed [31:0] right_y;
		logic signed [31:0] right_z;
		logic signed [31:0] upward_x;
		logic signed [31:0] upward_y;
		logic signed [31:0] upward_z;
		logic signed [31:0] back_x;
		logic signed [31:0] back_y;
		logic signed [31:0] back_z;
		logic               degenerate;
	} res_t;

endpackage

// File: rtl/lar_cross.sv
// Two-stage cross product of two Q2.30 / Q16.16 axis vectors.
// Stage one forms the six products, stage two the three differences.
// Depends on lar_pkg.
module lar_cross #(
	parameter int SIDE_W = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   in_valid,
	input  lar_pkg::axis_t [2:0]   a,
	input  lar_pkg::axis_t [2:0]   b,
	input  logic [SIDE_W-1:0]      in_side,
	output logic                   out_valid,
	output lar_pkg::wide_t [2:0]   out_vec,
	output logic [SIDE_W-1:0]      out_side
);
	import lar_pkg::*;

	logic              v_s1;
	wide_t             p_s1 [6];
	logic [SIDE_W-1:0] side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1[0]  <= $signed(a[1]) * $signed(b[2]);
			p_s1[1]  <= $signed(a[2]) * $signed(b[1]);
			p_s1[2]  <= $signed(a[2]) * $signed(b[0]);
			p_s1[3]  <= $signed(a[0]) * $signed(b[2]);
			p_s1[4]  <= $signed(a[0]) * $signed(b[1]);
			p_s1[5]  <= $signed(a[1]) * $signed(b[0]);
			side_s1  <= in_side;
			out_vec[0] <= p_s1[0] - p_s1[1];
			out_vec[1] <= p_s1[2] - p_s1[3];
			out_vec[2] <= p_s1[4] - p_s1[5];
			out_side <= side_s1;
		end
	end

endmodule

// File: rtl/lar_unit.sv
// Pipelined normalizer for one three-component vector.
// Scales, squares, takes a digit-per-stage square root, then divides each
// lane one quotient bit per stage. Depends on lar_pkg.
module lar_unit #(
	parameter int SIDE_W = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   in_valid,
	input  lar_pkg::wide_t [2:0]   in_vec,
	input  logic [SIDE_W-1:0]      in_side,
	output logic                   out_valid,
	output lar_pkg::axis_t [2:0]   out_vec,
	output logic                   out_ok,
	output logic [SIDE_W-1:0]      out_side
);
	import lar_pkg::*;

	localparam int RT_STEPS = 32;
	localparam int DV_STEPS = 31;

	typedef struct packed {
		logic            zero;
		logic [2:0]      neg;
		logic [2:0][30:0] m;
	} pay_t;

	function automatic logic [5:0] bit_len(input logic [61:0] v);
		logic [5:0] n;
		n = '0;
		for (int i = 0; i < 62; i++) begin
			if (v[i]) n = 6'(i + 1);
		end
		return n;
	endfunction

	// Sign and magnitude.
	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2:0]        neg_s1, neg_s2;
	logic [2:0][61:0]  mag_s1, mag_s2;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [5:0]        nlen_s2;
	logic              zero_s2;
	pay_t              pay_s3, pay_s4, pay_s5;
	logic [2:0][61:0]  sq_s4;
	logic [63:0]       sum_s5;
	logic [2:0][30:0]  scaled;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (nlen_s2 < 6'd31) begin
				scaled[i] = 31'(mag_s2[i] << (6'd31 - nlen_s2));
			end else begin
				scaled[i] = 31'(mag_s2[i] >> (nlen_s2 - 6'd31));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= in_vec[i][WIDE_W-1];
				mag_s1[i] <= in_vec[i][WIDE_W-1] ? 62'(-in_vec[i]) : in_vec[i][61:0];
			end
			side_s1 <= in_side;
			// The bit length of the largest magnitude equals that of the OR.
			nlen_s2 <= bit_len(mag_s1[0] | mag_s1[1] | mag_s1[2]);
			zero_s2 <= ~|(mag_s1[0] | mag_s1[1] | mag_s1[2]);
			neg_s2  <= neg_s1;
			mag_s2  <= mag_s1;
			side_s2 <= side_s1;
			pay_s3.zero <= zero_s2;
			pay_s3.neg  <= neg_s2;
			pay_s3.m    <= scaled;
			side_s3 <= side_s2;
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= 62'(pay_s3.m[i]) * 62'(pay_s3.m[i]);
			end
			pay_s4  <= pay_s3;
			side_s4 <= side_s3;
			sum_s5  <= 64'(sq_s4[0]) + 64'(sq_s4[1]) + 64'(sq_s4[2]);
			pay_s5  <= pay_s4;
			side_s5 <= side_s4;
		end
	end

	// Square root, two radicand bits per stage.
	logic              rt_v_s    [0:RT_STEPS];
	pay_t              rt_p_s    [0:RT_STEPS];
	logic [SIDE_W-1:0] rt_side_s [0:RT_STEPS];
	logic [33:0]       rt_rem_s  [0:RT_STEPS];
	logic [31:0]       rt_root_s [0:RT_STEPS];
	logic [63:0]       rt_val_s  [0:RT_STEPS];

	assign rt_v_s[0]    = v_s5;
	assign rt_p_s[0]    = pay_s5;
	assign rt_side_s[0] = side_s5;
	assign rt_rem_s[0]  = '0;
	assign rt_root_s[0] = '0;
	assign rt_val_s[0]  = sum_s5;

	for (genvar k = 0; k < RT_STEPS; k++) begin : g_rt
		logic [35:0] cur;
		logic [35:0] trial;
		logic        take;

		assign cur   = {rt_rem_s[k], rt_val_s[k][63:62]};
		assign trial = {2'b00, rt_root_s[k], 2'b01};
		assign take  = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				rt_v_s[k+1] <= rt_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rt_rem_s[k+1]  <= take ? 34'(cur - trial) : cur[33:0];
				rt_root_s[k+1] <= {rt_root_s[k][30:0], take};
				rt_val_s[k+1]  <= {rt_val_s[k][61:0], 2'b00};
				rt_p_s[k+1]    <= rt_p_s[k];
				rt_side_s[k+1] <= rt_side_s[k];
			end
		end
	end

	// Restoring division, one quotient bit per stage in each lane.
	logic              dv_v_s    [0:DV_STEPS];
	pay_t              dv_p_s    [0:DV_STEPS];
	logic [SIDE_W-1:0] dv_side_s [0:DV_STEPS];
	logic [31:0]       dv_len_s  [0:DV_STEPS];
	logic [2:0][31:0]  dv_rem_s  [0:DV_STEPS];
	logic [2:0][30:0]  dv_lo_s   [0:DV_STEPS];
	logic [2:0][30:0]  dv_q_s    [0:DV_STEPS];
	logic [2:0][61:0]  num;

	// The numerator is m * 2^30 plus half the length, for rounding.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[i] = 62'({rt_p_s[RT_STEPS].m[i], 30'b0})
				+ 62'(rt_root_s[RT_STEPS][31:1]);
			dv_rem_s[0][i] = {1'b0, num[i][61:31]};
			dv_lo_s[0][i]  = num[i][30:0];
			dv_q_s[0][i]   = '0;
		end
	end

	assign dv_v_s[0]    = rt_v_s[RT_STEPS];
	assign dv_p_s[0]    = rt_p_s[RT_STEPS];
	assign dv_side_s[0] = rt_side_s[RT_STEPS];
	assign dv_len_s[0]  = rt_root_s[RT_STEPS];

	for (genvar j = 0; j < DV_STEPS; j++) begin : g_dv
		logic [2:0][32:0] cur;
		logic [2:0]       take;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				cur[i]  = {dv_rem_s[j][i], dv_lo_s[j][i][30]};
				take[i] = cur[i] >= {1'b0, dv_len_s[j]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else if (adv) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int i = 0; i < 3; i++) begin
					dv_rem_s[j+1][i] <= take[i] ? 32'(cur[i] - {1'b0, dv_len_s[j]})
						: cur[i][31:0];
					dv_lo_s[j+1][i]  <= {dv_lo_s[j][i][29:0], 1'b0};
					dv_q_s[j+1][i]   <= {dv_q_s[j][i][29:0], take[i]};
				end
				dv_len_s[j+1]  <= dv_len_s[j];
				dv_p_s[j+1]    <= dv_p_s[j];
				dv_side_s[j+1] <= dv_side_s[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= dv_v_s[DV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				out_vec[i] <= dv_p_s[DV_STEPS].neg[i]
					? 32'(-{1'b0, dv_q_s[DV_STEPS][i]})
					: {1'b0, dv_q_s[DV_STEPS][i]};
			end
			out_ok   <= !dv_p_s[DV_STEPS].zero;
			out_side <= dv_side_s[DV_STEPS];
		end
	end

endmodule

// File: rtl/look_at_rotation_basis.sv
// Top level of the look-at rotation basis pipeline.
// Chains the difference stage, three normalizers and two cross products.
// Depends on lar_pkg, lar_unit and lar_cross.
//
// Usage: a request on req (eye, target and up, signed Q16.16) is taken when
// req_valid and req_ready are both high. Each request gives exactly one
// result on res (right, upward and back axes in signed Q2.30 and the
// degenerate flag), offered with res_valid until res_ready takes it.
// A degenerate result has all nine axis fields at zero.
// The path from request to result runs through one difference stage, three
// normalizers of 69 stages each (five for scaling and squares, 32 for the
// square root, 31 for the lane division, one for the sign), two cross
// products of two stages each, and the result register.
// Throughput is one request per cycle unless the result stalls; the square
// root and the dividers are fully pipelined, one digit per stage.
// Reset clears every valid bit; no result is shown after reset until a
// request has gone through. When the result register holds a result that
// is not taken, the whole pipeline holds, req_ready drops, and nothing is
// lost or repeated.
module look_at_rotation_basis (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  lar_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output lar_pkg::res_t res
);
	import lar_pkg::*;

	typedef struct packed {
		axis_t [2:0] back;
		logic        ok;
	} mid_t;

	typedef struct packed {
		axis_t [2:0] back;
		axis_t [2:0] right;
		logic        ok;
	} late_t;

	logic        adv;
	logic        v_s1;
	wide_t [2:0] d_s1;
	axis_t [2:0] up_s1;

	logic        u1_valid, u1_ok;
	axis_t [2:0] u1_vec, u1_up;
	logic        c1_valid;
	wide_t [2:0] c1_vec;
	mid_t        c1_side_in, c1_side;
	logic        u2_valid, u2_ok;
	axis_t [2:0] u2_vec;
	mid_t        u2_side;
	logic        c2_valid;
	wide_t [2:0] c2_vec;
	late_t       c2_side_in, c2_side;
	logic        u3_valid, u3_ok;
	axis_t [2:0] u3_vec;
	late_t       u3_side;
	logic        res_valid_q;
	res_t        res_q;
	logic        good;

	assign adv       = !res_valid_q || res_ready;
	assign req_ready = adv;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1[0]  <= wide_t'(req.eye_x) - wide_t'(req.target_x);
			d_s1[1]  <= wide_t'(req.eye_y) - wide_t'(req.target_y);
			d_s1[2]  <= wide_t'(req.eye_z) - wide_t'(req.target_z);
			up_s1[0] <= req.up_x;
			up_s1[1] <= req.up_y;
			up_s1[2] <= req.up_z;
		end
	end

	lar_unit #(.SIDE_W(3 * AXIS_W)) u_back (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(v_s1), .in_vec(d_s1), .in_side(up_s1),
		.out_valid(u1_valid), .out_vec(u1_vec), .out_ok(u1_ok), .out_side(u1_up)
	);

	assign c1_side_in.back = u1_vec;
	assign c1_side_in.ok   = u1_ok;

	lar_cross #(.SIDE_W($bits(mid_t))) u_cross_up (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(u1_valid), .a(u1_up), .b(u1_vec), .in_side(c1_side_in),
		.out_valid(c1_valid), .out_vec(c1_vec), .out_side(c1_side)
	);

	lar_unit #(.SIDE_W($bits(mid_t))) u_right (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(c1_valid), .in_vec(c1_vec), .in_side(c1_side),
		.out_valid(u2_valid), .out_vec(u2_vec), .out_ok(u2_ok), .out_side(u2_side)
	);

	assign c2_side_in.back  = u2_side.back;
	assign c2_side_in.right = u2_vec;
	assign c2_side_in.ok    = u2_side.ok && u2_ok;

	lar_cross #(.SIDE_W($bits(late_t))) u_cross_back (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(u2_valid), .a(u2_side.back), .b(u2_vec), .in_side(c2_side_in),
		.out_valid(c2_valid), .out_vec(c2_vec), .out_side(c2_side)
	);

	lar_unit #(.SIDE_W($bits(late_t))) u_upward (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(c2_valid), .in_vec(c2_vec), .in_side(c2_side),
		.out_valid(u3_valid), .out_vec(u3_vec), .out_ok(u3_ok), .out_side(u3_side)
	);

	assign good = u3_side.ok && u3_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= u3_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.right_x    <= good ? u3_side.right[0] : '0;
			res_q.right_y    <= good ? u3_side.right[1] : '0;
			res_q.right_z    <= good ? u3_side.right[2] : '0;
			res_q.upward_x   <= good ? u3_vec[0] : '0;
			res_q.upward_y   <= good ? u3_vec[1] : '0;
			res_q.upward_z   <= good ? u3_vec[2] : '0;
			res_q.back_x     <= good ? u3_side.back[0] : '0;
			res_q.back_y     <= good ? u3_side.back[1] : '0;
			res_q.back_z     <= good ? u3_side.back[2] : '0;
			res_q.degenerate <= !good;
		end
	end

`ifndef SYNTHESIS
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |-> !req_ready)
		else $error("request taken while result stalled");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.degenerate) |-> (res.right_x == 0 && res.upward_y == 0
			&& res.back_z == 0 && res.back_x == 0))
		else $error("degenerate result carries nonzero axes");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.degenerate) |-> (res.back_x <= 32'sd1073741824
			&& res.back_x >= -32'sd1073741824 && res.right_y <= 32'sd1073741824
			&& res.right_y >= -32'sd1073741824))
		else $error("axis component out of unit range");
`endif

endmodule
